// ===== rtl/core/asms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the approximate substring match scorer.
// No dependencies; imported by asms_cell, approximate_substring_match_score and the testbench.
package asms_pkg;

    localparam int CHAR_W   = 8;
    localparam int RESULT_W = 6;

    // item commands
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_SOURCE = 1'b1;

    // control part of a source character moving along the cell chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] ch;
    } tok_ctrl_t;

endpackage

// ===== rtl/core/approximate_substring_match_score.sv =====
`timescale 1ns / 1ps
// Top level of the approximate substring match scorer: a chain of asms_cell
// instances plus query bookkeeping and the result register. Depends on asms_pkg.
//
// Usage: items arrive on item_valid/item_ready with command, char_code and
// last_char. A query item (command 0) appends a character to the stored query;
// a query item after a completed query starts a new one. Query characters past
// MAX_QUERY are dropped and reported in query_overflow. A source item
// (command 1) streams one character through the chain; the item with last_char
// set produces one result on result_valid/result_ready.
// Throughput: one source item per cycle while the chain is not held; the chain
// is skewed so each cell handles a character after its upper neighbor has
// registered it. A final source item sets result_valid once it has left the last cell.
// A query item waits until no source item is in the chain, that is until the
// last source item has left the final cell, and longer while a result stalls.
// Reset clears the query, the overflow flag and all column costs.
// If a result waits unread and another final source character reaches the
// end of the chain, the whole chain holds and item_ready stays low.
module approximate_substring_match_score import asms_pkg::*; #(
    parameter int MAX_QUERY = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                command,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                last_char,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [RESULT_W-1:0] match_count,
    output logic [RESULT_W-1:0] min_distance,
    output logic                query_overflow
);

    localparam int COST_W = $clog2(MAX_QUERY + 1);
    localparam int CNT_W  = $clog2(MAX_QUERY + 2);
    localparam logic [COST_W-1:0] MaxLenC = COST_W'(MAX_QUERY);

    tok_ctrl_t         tok_chain   [0:MAX_QUERY];
    logic [COST_W-1:0] above_chain [0:MAX_QUERY];
    logic [COST_W-1:0] diag_chain  [0:MAX_QUERY];
    logic [MAX_QUERY-1:0] load_en;

    logic [COST_W-1:0] qlen_reg, qlen_next;
    logic              ovf_reg, ovf_next;
    logic              complete_reg, complete_next;
    logic [COST_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]  inflight_reg, inflight_next;
    logic              out_valid_reg;
    logic [RESULT_W-1:0] match_reg, dist_reg;
    logic              out_ovf_reg;

    logic              advance;
    logic              accept;
    logic              src_accept;
    logic              qry_accept;
    logic              exit_tok;
    logic              exit_last;
    logic              do_store;
    logic [COST_W-1:0] base_len;
    logic [COST_W-1:0] nb;

    // chain holds only when a final result must land in a full output register
    assign exit_tok  = tok_chain[MAX_QUERY].valid;
    assign exit_last = exit_tok && tok_chain[MAX_QUERY].last;
    assign advance   = !(out_valid_reg && !result_ready && exit_last);

    // query items wait for an empty chain
    assign item_ready = advance && ((command == CMD_SOURCE) || (inflight_reg == '0));
    assign accept     = item_valid && item_ready;
    assign src_accept = accept && (command == CMD_SOURCE);
    assign qry_accept = accept && (command == CMD_QUERY);

    // head of the chain
    assign tok_chain[0]   = {src_accept, last_char, char_code};
    assign above_chain[0] = '0;
    assign diag_chain[0]  = '0;

    // query append bookkeeping
    assign base_len = complete_reg ? '0 : qlen_reg;
    assign do_store = qry_accept && (base_len < MaxLenC);

    always_comb
    begin
        qlen_next     = qlen_reg;
        ovf_next      = ovf_reg;
        complete_next = complete_reg;
        if (qry_accept)
        begin
            ovf_next      = complete_reg ? 1'b0 : ovf_reg;
            complete_next = last_char;
            if (base_len < MaxLenC)
            begin
                qlen_next = base_len + COST_W'(1);
            end
            else
            begin
                qlen_next = base_len;
                ovf_next  = 1'b1;
            end
        end
    end

    // cell chain
    genvar g;
    generate
        for (g = 0; g < MAX_QUERY; g++)
        begin : g_cell
            assign load_en[g] = do_store && (base_len == COST_W'(g));

            asms_cell #(
                .COST_W (COST_W),
                .IDX    (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .clear_all (qry_accept),
                .load_en   (load_en[g]),
                .load_char (char_code),
                .qlen      (qlen_reg),
                .tok_in    (tok_chain[g]),
                .above_in  (above_chain[g]),
                .diag_in   (diag_chain[g]),
                .tok_out   (tok_chain[g+1]),
                .above_out (above_chain[g+1]),
                .diag_out  (diag_chain[g+1])
            );
        end
    endgenerate

    // running best over end positions
    assign nb = ((qlen_reg != '0) && (above_chain[MAX_QUERY] < best_reg)) ?
                above_chain[MAX_QUERY] : best_reg;

    always_comb
    begin
        best_next = best_reg;
        if (qry_accept)
        begin
            best_next = qlen_next;
        end
        else if (advance && exit_tok)
        begin
            best_next = exit_last ? qlen_reg : nb;
        end
    end

    // source items in the chain
    always_comb
    begin
        inflight_next = inflight_reg;
        if (src_accept && !(advance && exit_tok))
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!src_accept && advance && exit_tok)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            complete_reg  <= 1'b0;
            best_reg      <= '0;
            inflight_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            qlen_reg     <= qlen_next;
            ovf_reg      <= ovf_next;
            complete_reg <= complete_next;
            best_reg     <= best_next;
            inflight_reg <= inflight_next;
            if (advance && exit_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && exit_last)
        begin
            match_reg   <= RESULT_W'(qlen_reg - nb);
            dist_reg    <= RESULT_W'(nb);
            out_ovf_reg <= ovf_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign match_count    = match_reg;
    assign min_distance   = dist_reg;
    assign query_overflow = out_ovf_reg;

endmodule

// ===== rtl/core/asms_cell.sv =====
`timescale 1ns / 1ps
// One cell of the edit-distance chain: holds one query character and its column cost.
// Depends on asms_pkg for the token type and character width.
module asms_cell import asms_pkg::*; #(
    parameter int COST_W = 6,
    parameter int IDX    = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              clear_all,
    input  logic              load_en,
    input  logic [CHAR_W-1:0] load_char,
    input  logic [COST_W-1:0] qlen,
    input  tok_ctrl_t         tok_in,
    input  logic [COST_W-1:0] above_in,
    input  logic [COST_W-1:0] diag_in,
    output tok_ctrl_t         tok_out,
    output logic [COST_W-1:0] above_out,
    output logic [COST_W-1:0] diag_out
);

    localparam logic [COST_W-1:0] IdxC   = COST_W'(IDX);
    localparam logic [COST_W-1:0] ClearC = COST_W'(IDX + 1);

    logic [CHAR_W-1:0] char_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    tok_ctrl_t         tok_reg;
    logic [COST_W-1:0] above_reg;
    logic [COST_W-1:0] diag_reg;

    logic              active;
    logic              sub;
    logic [COST_W:0]   del_cost;
    logic [COST_W:0]   ins_cost;
    logic [COST_W:0]   sub_cost;
    logic [COST_W:0]   min_ab;
    logic [COST_W:0]   min_all;
    logic [COST_W-1:0] v;

    // cell takes part only for query positions below the length
    assign active = tok_in.valid && (IdxC < qlen);
    assign sub    = (char_reg != tok_in.ch);

    // three-way minimum of the edit recurrence
    always_comb
    begin
        del_cost = {1'b0, cost_reg} + (COST_W+1)'(1);
        ins_cost = {1'b0, above_in} + (COST_W+1)'(1);
        sub_cost = {1'b0, diag_in} + (COST_W+1)'(sub);
        min_ab   = (del_cost < ins_cost) ? del_cost : ins_cost;
        min_all  = (min_ab < sub_cost) ? min_ab : sub_cost;
        v        = min_all[COST_W-1:0];
    end

    // cost update, cleared after the final source character and on every query item
    always_comb
    begin
        cost_next = cost_reg;
        if (clear_all)
        begin
            cost_next = ClearC;
        end
        else if (advance && active)
        begin
            cost_next = tok_in.last ? ClearC : v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg <= ClearC;
            tok_reg  <= '0;
        end
        else
        begin
            cost_reg <= cost_next;
            if (advance)
            begin
                tok_reg <= tok_in;
            end
        end
    end

    // neighbor handoff payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            above_reg <= active ? v : above_in;
            diag_reg  <= cost_reg;
        end
    end

    // query character storage
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            char_reg <= load_char;
        end
    end

    assign tok_out   = tok_reg;
    assign above_out = above_reg;
    assign diag_out  = diag_reg;

endmodule

// ===== bench/tb_approximate_substring_match_score.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for approximate_substring_match_score: directed and random
// query/source items with a score predictor. Depends on asms_pkg and the top level.
module tb_approximate_substring_match_score import asms_pkg::*; ();

    // predicts the semi-global edit distance scores and holds the ones still due
    class score_tracker #(int DEPTH = 32);

        typedef struct packed {
            logic [RESULT_W-1:0] match_count;
            logic [RESULT_W-1:0] min_distance;
            logic                query_overflow;
        } score_t;

        logic [CHAR_W-1:0]   query_chars [DEPTH];
        logic [RESULT_W-1:0] query_len;
        logic [RESULT_W-1:0] costs [DEPTH];
        logic [RESULT_W-1:0] best;
        logic                dropped;
        logic                closed;
        score_t              scores_due [$];
        int                  mismatches;

        function new();
            foreach (query_chars[q])
                query_chars[q] = '0;
            query_len  = '0;
            dropped    = 1'b0;
            closed     = 1'b0;
            mismatches = 0;
            clear_costs();
        endfunction

        // column back to the empty-source costs for the current length
        function void clear_costs();
            foreach (costs[q])
                costs[q] = RESULT_W'(q + 1);
            best = query_len;
        endfunction

        // update the prediction for one accepted item
        function void absorb_char(logic cmd, logic [CHAR_W-1:0] ch, logic last);
            int     upper_new;
            int     upper_old;
            int     prev;
            int     cand;
            score_t s;
            if (cmd == CMD_QUERY)
            begin
                // an append after a finished query starts a new one
                if (closed)
                begin
                    query_len = '0;
                    dropped   = 1'b0;
                    closed    = 1'b0;
                end
                if (query_len < DEPTH)
                begin
                    query_chars[query_len] = ch;
                    query_len = query_len + 1'b1;
                end
                else
                    dropped = 1'b1;
                if (last)
                    closed = 1'b1;
                clear_costs();
            end
            else
            begin
                // one column step; the row above the query costs nothing
                upper_new = 0;
                upper_old = 0;
                for (int q = 0; q < query_len; q++)
                begin
                    prev = costs[q];
                    cand = upper_old + ((query_chars[q] != ch) ? 1 : 0);
                    if (prev + 1 < cand)
                        cand = prev + 1;
                    if (upper_new + 1 < cand)
                        cand = upper_new + 1;
                    costs[q]  = cand[RESULT_W-1:0];
                    upper_old = prev;
                    upper_new = cand;
                end
                if (query_len != 0 && upper_new < best)
                    best = upper_new[RESULT_W-1:0];
                if (last)
                begin
                    s.match_count    = query_len - best;
                    s.min_distance   = best;
                    s.query_overflow = dropped;
                    scores_due.insert(scores_due.size(), s);
                    clear_costs();
                end
            end
        endfunction

        // compare one accepted result with the oldest score due
        function void check_score(logic [RESULT_W-1:0] mc, logic [RESULT_W-1:0] md, logic qo);
            score_t want;
            if (scores_due.size() == 0)
            begin
                $error("unexpected result: match_count %0d min_distance %0d query_overflow %0d",
                       mc, md, qo);
                mismatches++;
            end
            else
            begin
                want = scores_due.pop_front();
                if (mc !== want.match_count)
                begin
                    $error("match_count: expected %0d, got %0d", want.match_count, mc);
                    mismatches++;
                end
                if (md !== want.min_distance)
                begin
                    $error("min_distance: expected %0d, got %0d", want.min_distance, md);
                    mismatches++;
                end
                if (qo !== want.query_overflow)
                begin
                    $error("query_overflow: expected %0d, got %0d", want.query_overflow, qo);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return scores_due.size();
        endfunction

    endclass

    localparam int MAX_Q       = 32;
    localparam int TOTAL_ITEMS = 1050;
    localparam int STALL_LIMIT = 4000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    logic                command      = CMD_QUERY;
    logic [CHAR_W-1:0]   char_code    = '0;
    logic                last_char    = 1'b0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [RESULT_W-1:0] match_count;
    logic [RESULT_W-1:0] min_distance;
    logic                query_overflow;

    score_tracker #(MAX_Q) tracker;
    logic [CHAR_W-1:0]     query_copy [$];
    bit                    query_open  = 1'b1;
    bit                    calm        = 1'b0;
    int                    items_sent  = 0;
    int                    quiet_cycles = 0;

    approximate_substring_match_score #(
        .MAX_QUERY(MAX_Q)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .char_code     (char_code),
        .last_char     (last_char),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .match_count   (match_count),
        .min_distance  (min_distance),
        .query_overflow(query_overflow)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // mostly small alphabet so that matches happen, sometimes any code
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(3) == 0)
            return CHAR_W'($urandom_range(255));
        return CHAR_W'(8'h61 + $urandom_range(3));
    endfunction

    // present one item, with random idle cycles ahead, and wait for its accept
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch, input logic last);
        while (!calm && $urandom_range(99) < 8)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        char_code  <= ch;
        last_char  <= last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        tracker.absorb_char(cmd, ch, last);
        // local copy of the stored query, used to build matching sources
        if (cmd == CMD_QUERY)
        begin
            if (!query_open)
                query_copy.delete();
            if (query_copy.size() < MAX_Q)
                query_copy.insert(query_copy.size(), ch);
            query_open = !last;
        end
        items_sent++;
        calm = (items_sent >= 400 && items_sent < 600);
    endtask

    // receiver stalls at random outside the calm stretch
    always @(posedge clk)
        result_ready <= calm || ($urandom_range(99) >= 8);

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_score(match_count, min_distance, query_overflow);
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int                qn;
        int                sn;
        int                off;
        int                extra;
        bit                open_tail;
        bit                embed;
        logic [CHAR_W-1:0] c;

        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty query: final source character scores zero
        send_item(CMD_SOURCE, 8'h00, 1'b1);
        // source before the query is complete
        send_item(CMD_QUERY,  8'h00, 1'b0);
        send_item(CMD_SOURCE, 8'h00, 1'b1);
        send_item(CMD_QUERY,  8'hFF, 1'b1);
        // exact occurrence inside the source
        send_item(CMD_SOURCE, 8'h12, 1'b0);
        send_item(CMD_SOURCE, 8'h00, 1'b0);
        send_item(CMD_SOURCE, 8'hFF, 1'b1);
        // single mismatching character
        send_item(CMD_SOURCE, 8'h55, 1'b1);
        // append after a finished query starts a new one
        send_item(CMD_QUERY,  8'h80, 1'b0);
        send_item(CMD_QUERY,  8'h7F, 1'b1);
        send_item(CMD_SOURCE, 8'h7F, 1'b0);
        send_item(CMD_SOURCE, 8'h80, 1'b1);
        send_item(CMD_QUERY,  8'hAA, 1'b1);
        // query item in the middle of a source starts a new query and clears the column
        send_item(CMD_SOURCE, 8'hAA, 1'b0);
        send_item(CMD_QUERY,  8'h01, 1'b0);
        send_item(CMD_SOURCE, 8'h01, 1'b1);

        // random query and source strings
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(99) < 18 || query_copy.size() == 0)
            begin
                // new query, now and then past capacity or left open
                qn = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
                open_tail = ($urandom_range(9) == 0);
                for (int k = 0; k < qn; k++)
                    send_item(CMD_QUERY, pick_char(), (k == qn - 1) && !open_tail);
            end
            else
            begin
                // source string, often holding a mutated copy of the query
                embed = ($urandom_range(99) < 60);
                extra = $urandom_range(6);
                if (embed)
                    sn = query_copy.size() + extra;
                else if ($urandom_range(19) == 0)
                    sn = $urandom_range(40, 20);
                else
                    sn = $urandom_range(10, 1);
                off = $urandom_range(extra);
                for (int k = 0; k < sn; k++)
                begin
                    if (k != sn - 1 && $urandom_range(99) < 2)
                        send_item(CMD_QUERY, pick_char(), 1'($urandom_range(1)));
                    if (embed && k >= off && k - off < query_copy.size()
                        && $urandom_range(99) >= 15)
                        c = query_copy[k - off];
                    else
                        c = pick_char();
                    send_item(CMD_SOURCE, c, k == sn - 1);
                end
            end
        end
        item_valid <= 1'b0;

        // drain the scores still due, then let the chain settle
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2 * MAX_Q) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/asms_pkg.sv
rtl/core/asms_cell.sv
rtl/core/approximate_substring_match_score.sv
bench/tb_approximate_substring_match_score.sv
